// ===== hdl/base64_stream_codec_core_macros.svh =====
// Assertion macros for the base64 stream codec.
// Used by modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef BASE64_STREAM_CODEC_CORE_MACROS_SVH
`define BASE64_STREAM_CODEC_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define B64C_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define B64C_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define B64C_ASSERT(lbl, expr, msg)
`define B64C_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/b64c_pkg.sv =====
// Shared types, constants and alphabet functions for the base64 stream codec.
// No dependencies.
`default_nettype none
package b64c_pkg;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] IDX_BAD    = 8'hFF;
    localparam logic       REG_MODE   = 1'b0;

    // One unit of back-end work: a finished group and how many results it gives.
    typedef struct packed {
        logic [23:0] store;
        logic        enc;
        logic [2:0]  cnt;   // encode: real characters, decode: bytes
        logic        last;
    } t_job;

    function automatic logic [7:0] char_index(input logic [7:0] c);
        logic [7:0] r;
        r = IDX_BAD;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c - 8'd65;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'd71;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = c + 8'd4;
        end else if (c == 8'h2B) begin
            r = 8'd62;
        end else if (c == 8'h2F) begin
            r = 8'd63;
        end
        return r;
    endfunction

    function automatic logic [7:0] alpha_char(input logic [5:0] s);
        logic [7:0] r;
        logic [7:0] w;
        w = {2'b00, s};
        if (s < 6'd26) begin
            r = w + 8'd65;
        end else if (s < 6'd52) begin
            r = w + 8'd71;
        end else if (s < 6'd62) begin
            r = w - 8'd4;
        end else if (s == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/b64c_front.sv =====
// Front end: accepts items, gathers groups and issues finished groups as jobs.
// Depends on b64c_pkg.
`default_nettype none
module b64c_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_data,
    input  wire                 i_last,
    input  wire                 i_mode,
    input  wire                 i_clear,
    input  wire                 i_q_ready,
    output logic                o_ready,
    output logic                o_push,
    output b64c_pkg::t_job      o_job
);

    logic [1:0]  r_count, n_count;
    logic [23:0] r_store, n_store;
    logic        r_pad,   n_pad;
    logic        has_job;
    logic [1:0]  cnt_up;
    logic [23:0] st;
    logic [7:0]  idx;
    logic        accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign o_push  = accept && has_job;

    always_comb begin
        n_count    = r_count;
        n_store    = r_store;
        n_pad      = r_pad;
        has_job    = 1'b0;
        o_job      = '0;
        o_job.enc  = (i_mode == b64c_pkg::MODE_ENCODE);
        o_job.last = i_last;
        st         = r_store;
        cnt_up     = r_count + 2'd1;
        idx        = b64c_pkg::char_index(i_data);
        if (i_mode == b64c_pkg::MODE_ENCODE) begin
            unique case (r_count)
                2'd0: st[23:16] = i_data;
                2'd1: st[15:8]  = i_data;
                default: st[7:0] = i_data;
            endcase
            if (cnt_up == 2'd3) begin
                has_job     = 1'b1;
                o_job.store = st;
                o_job.cnt   = 3'd4;
                n_count     = 2'd0;
                n_store     = '0;
            end else begin
                n_count = cnt_up;
                n_store = st;
                if (i_last) begin
                    has_job     = 1'b1;
                    o_job.store = st;
                    o_job.cnt   = {1'b0, cnt_up} + 3'd1;
                end
            end
        end else begin
            if (!r_pad) begin
                if (i_data == b64c_pkg::CHAR_PAD) begin
                    n_pad = 1'b1;
                end else begin
                    unique case (r_count)
                        2'd0: st[23:16] = {idx[5:0], 2'b00};
                        2'd1: begin
                            st[23:16] = r_store[23:16] + {6'd0, idx[5:4]};
                            st[15:8]  = {idx[3:0], 4'd0};
                        end
                        2'd2: begin
                            st[15:8] = r_store[15:8] + {4'd0, idx[5:2]};
                            st[7:0]  = {idx[1:0], 6'd0};
                        end
                        default: st[7:0] = r_store[7:0] + idx;
                    endcase
                    n_count = cnt_up;
                    n_store = st;
                    if (cnt_up == 2'd0) begin
                        has_job     = 1'b1;
                        o_job.store = st;
                        o_job.cnt   = 3'd3;
                        n_store     = '0;
                    end
                end
            end
            if (i_last && n_count > 2'd1) begin
                has_job     = 1'b1;
                o_job.store = n_store;
                o_job.cnt   = {1'b0, n_count} - 3'd1;
            end
        end
        if (i_last) begin
            n_count = 2'd0;
            n_store = '0;
            n_pad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= 2'd0;
            r_store <= '0;
            r_pad   <= 1'b0;
        end else if (accept) begin
            r_count <= n_count;
            r_store <= n_store;
            r_pad   <= n_pad;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/b64c_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on b64c_pkg.
`default_nettype none
module b64c_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  b64c_pkg::t_job      i_job,
    output logic                o_ready,
    input  wire                 i_pop,
    output logic                o_valid,
    output b64c_pkg::t_job      o_job
);

    b64c_pkg::t_job                r_mem [b64c_pkg::Q_DEPTH];
    logic [b64c_pkg::Q_AW-1:0]     r_wr;
    logic [b64c_pkg::Q_AW-1:0]     r_rd;
    logic [b64c_pkg::Q_AW:0]       r_count;

    assign o_valid = (r_count != '0);
    assign o_ready = (r_count != (b64c_pkg::Q_AW + 1)'(b64c_pkg::Q_DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/b64c_back.sv =====
// Back end: expands one job into characters or bytes, one per cycle while not stalled, into the output register.
// Depends on b64c_pkg and the codec assertion macros.
`default_nettype none
`include "base64_stream_codec_core_macros.svh"
module b64c_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  b64c_pkg::t_job      i_q_job,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [7:0]          o_out_data,
    output logic                o_out_run_end,
    output logic                o_out_message_end
);

    b64c_pkg::t_job r_job;
    logic           r_busy;
    logic [1:0]     r_k;
    logic           r_out_valid;
    logic [7:0]     r_out_data;
    logic           r_out_run_end;
    logic           r_out_msg_end;
    logic           out_free;
    logic           emit;
    logic           last_k;
    logic           fin;
    logic           take;
    logic [5:0]     sextet;
    logic [7:0]     res;

    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = r_busy && out_free;
    assign last_k   = r_job.enc ? (r_k == 2'd3) : ({1'b0, r_k} == (r_job.cnt - 3'd1));
    assign fin      = emit && last_k;
    assign take     = i_q_valid && (!r_busy || fin);
    assign o_q_pop  = take;

    always_comb begin
        unique case (r_k)
            2'd0: begin
                sextet = r_job.store[23:18];
            end
            2'd1: begin
                sextet = r_job.store[17:12];
            end
            2'd2: begin
                sextet = r_job.store[11:6];
            end
            default: begin
                sextet = r_job.store[5:0];
            end
        endcase
        if (r_job.enc) begin
            res = ({1'b0, r_k} < r_job.cnt) ? b64c_pkg::alpha_char(sextet)
                                             : b64c_pkg::CHAR_PAD;
        end else begin
            unique case (r_k)
                2'd0: res = r_job.store[23:16];
                2'd1: res = r_job.store[15:8];
                default: res = r_job.store[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_k <= r_k + 2'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_out_data    <= res;
            r_out_run_end <= last_k;
            r_out_msg_end <= last_k && r_job.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_out_run_end     = r_out_run_end;
    assign o_out_message_end = r_out_msg_end;

    `B64C_ASSERT_IMP(a_dec_cnt, r_busy && !r_job.enc, r_job.cnt != 3'd0 && r_job.cnt <= 3'd3, "decode job count out of range")
    `B64C_ASSERT_IMP(a_enc_cnt, r_busy && r_job.enc, r_job.cnt >= 3'd2 && r_job.cnt <= 3'd4, "encode job count out of range")
    `B64C_ASSERT_IMP(a_dec_k, r_busy && !r_job.enc, {1'b0, r_k} < r_job.cnt, "decode index past job end")
    `B64C_ASSERT_IMP(a_msg_run, o_out_valid && o_out_message_end, o_out_run_end, "message end without run end")

endmodule
`default_nettype wire

// ===== hdl/base64_stream_codec_core.sv =====
// Base64 stream codec, standard alphabet with '=' padding.
// Input channel: i_in_valid/o_in_ready with i_in_data and i_in_last; a transaction
//   carries one byte (encode) or one character (decode); i_in_last ends the message.
// Output channel: o_out_valid/i_out_ready with o_out_data, o_out_run_end (last result
//   of a group) and o_out_message_end (last result of the message).
// APB register 0 (bit 0) selects encode (0) or decode (1); writing it clears the group.
// Throughput: output is one result per cycle while i_out_ready is high. Encode accepts a byte
//   per cycle in bursts, but is held back over time by the four characters each group gives;
//   decode sustains one character per cycle while the output keeps up.
// A two-entry job queue separates the input side from the result expander, so input
//   keeps flowing while a result waits; once the queue fills, o_in_ready drops.
// Output stall holds o_out_* steady and backs up into the queue.
// Reset (synchronous, active low) clears mode to encode, the group state, the queue
//   and the output valid flag.
// Depends on b64c_pkg, b64c_front, b64c_queue and b64c_back.
`default_nettype none
module base64_stream_codec_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_in_data,
    input  wire         i_in_last,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_out_data,
    output logic        o_out_run_end,
    output logic        o_out_message_end,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic           r_mode;
    logic           cfg_wr;
    logic           push;
    logic           pop;
    logic           q_ready;
    logic           q_valid;
    b64c_pkg::t_job front_job;
    b64c_pkg::t_job q_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == b64c_pkg::REG_MODE);
    assign prdata = (paddr[2] == b64c_pkg::REG_MODE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= b64c_pkg::MODE_ENCODE;
        end else if (cfg_wr) begin
            r_mode <= pwdata[0];
        end
    end

    b64c_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .i_last    (i_in_last),
        .i_mode    (r_mode),
        .i_clear   (cfg_wr),
        .i_q_ready (q_ready),
        .o_ready   (o_in_ready),
        .o_push    (push),
        .o_job     (front_job)
    );

    b64c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b64c_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_job           (q_job),
        .o_q_pop           (pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_data        (o_out_data),
        .o_out_run_end     (o_out_run_end),
        .o_out_message_end (o_out_message_end)
    );

endmodule
`default_nettype wire
